// ===== sv/drs_pkg.sv =====
package drs_pkg;
    localparam int MaxItems   = 64;
    localparam int ValueW     = 31;
    localparam int Radix      = 10;
    localparam int DigitW     = 4;
    localparam int DigitTopLv = 9;

    typedef enum logic [3:0] {
        t_ST_LOAD,
        t_ST_CLR,
        t_ST_COUNT,
        t_ST_PREFIX,
        t_ST_PLACE,
        t_ST_COPY,
        t_ST_NEXT,
        t_ST_EMIT
    } t_state;

    typedef struct packed {
        logic load;
        logic clr_counts;
        logic count_en;
        logic prefix_en;
        logic place_en;
        logic copy_en;
        logic scale_up;
        logic finish;
        logic emit_en;
    } t_cmd;

    typedef struct packed {
        logic more_digits;
        logic any_items;
        logic sweep_done;
        logic prefix_done;
        logic emit_taken_last;
        logic full;
    } t_status;
endpackage

// ===== sv/drs_stream_if.sv =====
interface drs_stream_if #(parameter int DataW = 31);
    logic             valid;
    logic             ready;
    logic [DataW-1:0] value;
    logic             last;
    modport source (output valid, output value, output last, input ready);
    modport sink (input valid, input value, input last, output ready);
endinterface

// ===== sv/drs_ram.sv =====
module drs_ram #(
    parameter int Width = 31,
    parameter int Depth = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== sv/drs_datapath.sv =====
// Sweeps: the store read is registered, then the digit decoded from it is registered in r_dig.
module drs_datapath #(
    parameter int MaxItems = drs_pkg::MaxItems
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  drs_pkg::t_cmd         i_cmd,
    input  logic [drs_pkg::ValueW-1:0] i_value,
    output drs_pkg::t_status      o_status,
    output logic [drs_pkg::ValueW-1:0] o_value
);
    localparam int AW = $clog2(MaxItems) > 0 ? $clog2(MaxItems) : 1;
    localparam int CW = $clog2(MaxItems + 1);
    localparam int DigW = drs_pkg::DigitW;

    logic [CW-1:0]    r_count;
    logic [drs_pkg::ValueW-1:0] r_max;
    logic [DigW-1:0]  r_lvl;
    logic [CW-1:0]    r_idx;
    logic             r_rd_ok;
    logic [AW-1:0]    r_rd_addr;
    logic [CW-1:0]    r_cnt [drs_pkg::Radix];
    logic [DigW-1:0]  r_pidx;
    logic [drs_pkg::ValueW-1:0] r_mq;
    logic [DigW-1:0]  r_dig;
    logic             r_dig_ok;
    logic [drs_pkg::ValueW-1:0] r_dval;

    logic [drs_pkg::ValueW-1:0] st_rd, pb_rd;
    logic             st_we, pb_we;
    logic [AW-1:0]    st_wa, pb_wa, st_ra, pb_ra;
    logic [drs_pkg::ValueW-1:0] st_wd;
    logic [DigW-1:0]  dig;
    logic [CW-1:0]    cidx_m1;
    logic             sweep_end;
    logic             sweep_fin;

    // floor(v / 10^k) by reciprocal multiply, exact for every 31-bit v; zero past 10^9
    function automatic logic [drs_pkg::ValueW-1:0] div_pow10(
            input logic [drs_pkg::ValueW-1:0] v, input logic [DigW-1:0] k);
        logic [32:0] m;
        logic [5:0]  s;
        logic [63:0] p;
        logic [63:0] sh;
        case (k)
            4'd0: begin m = 33'd1; s = 6'd0; end
            4'd1: begin m = 33'((64'd1 << 35) / 64'd10 + 64'd1); s = 6'd35; end
            4'd2: begin m = 33'((64'd1 << 38) / 64'd100 + 64'd1); s = 6'd38; end
            4'd3: begin m = 33'((64'd1 << 41) / 64'd1000 + 64'd1); s = 6'd41; end
            4'd4: begin m = 33'((64'd1 << 45) / 64'd10000 + 64'd1); s = 6'd45; end
            4'd5: begin m = 33'((64'd1 << 48) / 64'd100000 + 64'd1); s = 6'd48; end
            4'd6: begin m = 33'((64'd1 << 51) / 64'd1000000 + 64'd1); s = 6'd51; end
            4'd7: begin m = 33'((64'd1 << 55) / 64'd10000000 + 64'd1); s = 6'd55; end
            4'd8: begin m = 33'((64'd1 << 58) / 64'd100000000 + 64'd1); s = 6'd58; end
            4'd9: begin m = 33'((64'd1 << 61) / 64'd1000000000 + 64'd1); s = 6'd61; end
            default: begin m = '0; s = 6'd0; end
        endcase
        p  = 64'(v) * 64'(m);
        sh = p >> s;
        return sh[drs_pkg::ValueW-1:0];
    endfunction

    // digit = floor(v/10^lvl) - 10*floor(v/10^(lvl+1))
    function automatic logic [DigW-1:0] digit_at(input logic [drs_pkg::ValueW-1:0] v,
                                                  input logic [DigW-1:0] lvl);
        logic [drs_pkg::ValueW-1:0] q_lo, q_hi, rem;
        q_lo = div_pow10(v, lvl);
        q_hi = div_pow10(v, lvl + DigW'(1));
        rem  = q_lo - ((q_hi << 3) + (q_hi << 1));
        return rem[DigW-1:0];
    endfunction

    drs_ram #(.Width(drs_pkg::ValueW), .Depth(1 << AW)) u_store (
        .i_clk(i_clk), .i_we(st_we), .i_waddr(st_wa), .i_wdata(st_wd),
        .i_raddr(st_ra), .o_rdata(st_rd));
    drs_ram #(.Width(drs_pkg::ValueW), .Depth(1 << AW)) u_pass (
        .i_clk(i_clk), .i_we(pb_we), .i_waddr(pb_wa), .i_wdata(r_dval),
        .i_raddr(pb_ra), .o_rdata(pb_rd));

    assign dig       = digit_at(st_rd, r_lvl);
    assign cidx_m1   = r_cnt[r_dig] - CW'(1);
    assign sweep_end = (r_idx == r_count);
    assign sweep_fin = sweep_end && !r_rd_ok && !r_dig_ok;

    always_comb begin
        st_we = 1'b0;
        st_wa = r_count[AW-1:0];
        st_wd = i_value;
        // outside sweeps the address trails the index so an emitted item holds
        st_ra = AW'(r_idx - CW'(1));
        pb_ra = r_idx[AW-1:0];
        pb_we = i_cmd.place_en && r_dig_ok;
        pb_wa = cidx_m1[AW-1:0];
        if (i_cmd.load && !o_status.full) begin
            st_we = 1'b1;
        end else if (i_cmd.copy_en && r_rd_ok) begin
            st_we = 1'b1;
            st_wa = r_rd_addr;
            st_wd = pb_rd;
        end
        if (i_cmd.count_en || i_cmd.copy_en) begin
            st_ra = r_idx[AW-1:0];
        end
        if (i_cmd.place_en) begin
            st_ra = AW'(r_count - r_idx - CW'(1));
        end
    end

    assign o_value = st_rd;
    assign o_status.full        = (r_count >= CW'(MaxItems));
    assign o_status.any_items   = (r_count != '0);
    assign o_status.sweep_done  = sweep_fin;
    assign o_status.prefix_done = (r_pidx == DigW'(drs_pkg::Radix - 1));
    assign o_status.more_digits = (r_mq != '0) && (r_lvl <= DigW'(drs_pkg::DigitTopLv));
    assign o_status.emit_taken_last = (r_idx == r_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_max    <= '0;
            r_lvl    <= '0;
            r_idx    <= '0;
            r_rd_ok  <= 1'b0;
            r_dig_ok <= 1'b0;
            r_pidx   <= '0;
            r_mq     <= '0;
            for (int k = 0; k < drs_pkg::Radix; k++) r_cnt[k] <= '0;
        end else begin
            r_rd_addr <= r_idx[AW-1:0];
            r_dig     <= dig;
            r_dval    <= st_rd;
            r_dig_ok  <= r_rd_ok && (i_cmd.count_en || i_cmd.place_en);
            if (i_cmd.load && !o_status.full) begin
                r_count <= r_count + CW'(1);
                if (i_value > r_max) begin
                    r_max <= i_value;
                    r_mq  <= i_value;
                end
            end
            if (i_cmd.clr_counts) begin
                for (int k = 0; k < drs_pkg::Radix; k++) r_cnt[k] <= '0;
                r_idx   <= '0;
                r_rd_ok <= 1'b0;
                r_pidx  <= DigW'(1);
            end
            if (i_cmd.count_en || i_cmd.place_en || i_cmd.copy_en) begin
                r_rd_ok <= !sweep_end;
                if (!sweep_end) r_idx <= r_idx + CW'(1);
                else if (sweep_fin) r_idx <= '0;
                if (i_cmd.count_en && r_dig_ok) r_cnt[r_dig] <= r_cnt[r_dig] + CW'(1);
                if (i_cmd.place_en && r_dig_ok) r_cnt[r_dig] <= cidx_m1;
            end
            if (i_cmd.prefix_en) begin
                r_cnt[r_pidx] <= r_cnt[r_pidx] + r_cnt[r_pidx - DigW'(1)];
                r_pidx <= r_pidx + DigW'(1);
                r_idx  <= '0;
            end
            if (i_cmd.scale_up) begin
                r_lvl <= r_lvl + DigW'(1);
                r_mq  <= div_pow10(r_mq, DigW'(1));
            end
            if (i_cmd.emit_en) begin
                r_idx <= r_idx + CW'(1);
            end
            if (i_cmd.finish) begin
                r_count <= '0;
                r_max   <= '0;
                r_mq    <= '0;
                r_lvl   <= '0;
                r_idx   <= '0;
            end
        end
    end

    check_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count == '0 |-> r_max == '0) else $error("max nonzero with empty store");
    check_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MaxItems)) else $error("count overflow");
    check_lvl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.scale_up |=> r_lvl == $past(r_lvl) + DigW'(1)) else $error("level step");
endmodule

// ===== sv/drs_ctrl.sv =====
module drs_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  drs_pkg::t_status i_status,
    input  logic             i_in_valid,
    input  logic             i_in_last,
    input  logic             i_out_ready,
    output logic             o_in_ready,
    output logic             o_out_valid,
    output logic             o_out_last,
    output drs_pkg::t_cmd    o_cmd
);
    drs_pkg::t_state r_state, n_state;
    logic r_ov, n_ov, r_ol, n_ol, r_first, n_first;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= drs_pkg::t_ST_LOAD;
            r_ov    <= 1'b0;
            r_ol    <= 1'b0;
            r_first <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ov    <= n_ov;
            r_ol    <= n_ol;
            r_first <= n_first;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_ov       = r_ov;
        n_ol       = r_ol;
        n_first    = 1'b0;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            drs_pkg::t_ST_LOAD: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_in_last) n_state = drs_pkg::t_ST_NEXT;
                end
            end
            drs_pkg::t_ST_NEXT: begin
                // decide whether another digit pass is needed
                if (i_status.more_digits) begin
                    o_cmd.clr_counts = 1'b1;
                    n_state = drs_pkg::t_ST_COUNT;
                end else if (i_status.any_items) begin
                    n_state = drs_pkg::t_ST_EMIT;
                    n_first = 1'b1;
                end else begin
                    o_cmd.finish = 1'b1;
                    n_state = drs_pkg::t_ST_LOAD;
                end
            end
            drs_pkg::t_ST_COUNT: begin
                o_cmd.count_en = 1'b1;
                if (i_status.sweep_done) n_state = drs_pkg::t_ST_PREFIX;
            end
            drs_pkg::t_ST_PREFIX: begin
                o_cmd.prefix_en = 1'b1;
                if (i_status.prefix_done) n_state = drs_pkg::t_ST_PLACE;
            end
            drs_pkg::t_ST_PLACE: begin
                o_cmd.place_en = 1'b1;
                if (i_status.sweep_done) n_state = drs_pkg::t_ST_COPY;
            end
            drs_pkg::t_ST_COPY: begin
                o_cmd.copy_en = 1'b1;
                if (i_status.sweep_done) begin
                    o_cmd.scale_up = 1'b1;
                    n_state = drs_pkg::t_ST_NEXT;
                end
            end
            drs_pkg::t_ST_EMIT: begin
                // store read is registered: advance address once the held item is taken
                if (r_first || (r_ov && i_out_ready) || (!r_ov && !r_first)) begin
                    if (r_ov && i_out_ready && r_ol) begin
                        n_ov = 1'b0;
                        n_ol = 1'b0;
                        o_cmd.finish = 1'b1;
                        n_state = drs_pkg::t_ST_LOAD;
                    end else if (r_first || (r_ov && i_out_ready)) begin
                        o_cmd.emit_en = 1'b1;
                        n_ov = 1'b0;
                        n_first = 1'b0;
                        n_state = drs_pkg::t_ST_CLR;
                    end
                end
            end
            drs_pkg::t_ST_CLR: begin
                // the address just issued is read here; its data is valid back in EMIT
                n_ov = 1'b1;
                n_ol = i_status.emit_taken_last;
                n_state = drs_pkg::t_ST_EMIT;
            end
            default: n_state = drs_pkg::t_ST_LOAD;
        endcase
    end

    assign o_out_valid = r_ov && (r_state == drs_pkg::t_ST_EMIT);
    assign o_out_last  = r_ol;

    check_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !o_in_ready) else $error("load during emit");
    check_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid) else $error("item dropped");
    check_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.count_en, o_cmd.place_en, o_cmd.copy_en, o_cmd.prefix_en}))
        else $error("overlapping sweeps");
endmodule

// ===== sv/decimal_radix_sort_unit.sv =====
// Decimal LSD radix sort: load up to MaxItems values, one per cycle; the item marked
// last starts the sort and is loaded unless the store is full. Each digit pass runs a
// count sweep, a nine-step prefix, a placement sweep and a copy sweep over the
// registered-read stores, with the digit decoded in a stage of its own, and passes
// run while max/10^k is nonzero, at most ten. Results then leave one at a time, the
// next fetched after each is taken, the last marked; no input is taken until all are out.
module decimal_radix_sort_unit #(
    parameter int MaxItems = drs_pkg::MaxItems
) (
    input logic           i_clk,
    input logic           i_rst_n,
    drs_stream_if.sink    in_if,
    drs_stream_if.source  out_if
);
    drs_pkg::t_cmd    cmd;
    drs_pkg::t_status status;

    drs_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_status(status),
        .i_in_valid(in_if.valid), .i_in_last(in_if.last), .i_out_ready(out_if.ready),
        .o_in_ready(in_if.ready), .o_out_valid(out_if.valid), .o_out_last(out_if.last),
        .o_cmd(cmd));

    drs_datapath #(.MaxItems(MaxItems)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .i_value(in_if.value),
        .o_status(status), .o_value(out_if.value));
endmodule
